@@ src/ufks_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ufks_pkg: shared types and constants of the keyword spotter
// Transaction payloads, UTF-8 lead byte codes, the keyword table and the
// keyword compare function used by the top level.
// ----------------------------------------------------------------------------
package ufks_pkg;

   localparam int LEN_W      = 8;
   localparam int KW_TABLE   = 8;
   localparam int KW_MAXLEN  = 13;
   localparam int KW_WINDOW  = KW_MAXLEN - 1;
   localparam int KW_LEN_W   = 4;

   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;
   localparam logic [7:0] LEAD_LATIN = 8'hC3;
   localparam logic [7:0] LEAD_OE    = 8'hC5;
   localparam logic [7:0] CONT_OE    = 8'h93;

   typedef logic [KW_MAXLEN*8-1:0] ufks_kw_type;
   typedef logic [KW_WINDOW-1:0][7:0] ufks_window_type;

   localparam ufks_kw_type KW_TEXT [KW_TABLE] = '{
      "indice", "aide", "hint", "bloque", "perdu",
      "comment faire", "je sais pas", "sais pas"
   };
   localparam logic [KW_LEN_W-1:0] KW_LEN [KW_TABLE] = '{
      4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd13, 4'd11, 4'd8
   };

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
      logic       is_final;
   } ufks_req_type;

   typedef struct packed {
      logic       hint_request;
      logic       any_keyword;
      logic [2:0] keyword_index;
      logic [7:0] folded_length;
   } ufks_rsp_type;

   typedef struct packed {
      logic [1:0] count;
      logic       pair;
      logic [7:0] char_a;
      logic [7:0] char_b;
   } ufks_emit_type;

   typedef enum logic [1:0] {
      SHIFT_HOLD,
      SHIFT_ONE,
      SHIFT_TWO
   } ufks_shift_type;

   function automatic logic [KW_TABLE-1:0] kw_match(input ufks_window_type win,
                                                    input logic [7:0] c);
      logic [KW_TABLE-1:0] hit;
      hit = '0;
      for (int k = 0; k < KW_TABLE; k++) begin
         hit[k] = (KW_TEXT[k][7:0] == c);
         for (int j = 1; j < KW_MAXLEN; j++) begin
            if ((KW_LEN_W'(j) < KW_LEN[k]) && (KW_TEXT[k][8*j +: 8] != win[KW_WINDOW-j])) begin
               hit[k] = 1'b0;
            end
         end
      end
      return hit;
   endfunction

endpackage
`default_nettype wire

@@ src/ufks_fold.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ufks_fold: UTF-8 to lower-case ASCII folding front end
// Holds an open multi-byte sequence and emits up to two folded characters per
// transaction, resolving a truncated sequence on the last byte.
// ----------------------------------------------------------------------------
module ufks_fold import ufks_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire logic [7:0]    text_byte,
   input  wire logic          last_byte,
   output ufks_emit_type      emit
);

   logic [7:0] held0_ff, held1_ff, held2_ff;
   logic [7:0] held0_in, held1_in, held2_in;
   logic [1:0] hcount_ff, hcount_in;
   logic [1:0] need_ff, need_in;

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      if (b inside {[8'h41:8'h5A]}) begin
         return b + 8'd32;
      end
      return b;
   endfunction

   function automatic logic [7:0] fold_latin(input logic [7:0] b1);
      case (b1)
         8'hA9, 8'hA8, 8'hAA, 8'hAB, 8'h89, 8'h88, 8'h8A, 8'h8B: return "e";
         8'hA0, 8'hA2, 8'hA4, 8'h80, 8'h82, 8'h84:               return "a";
         8'hAE, 8'hAF, 8'h8E, 8'h8F:                             return "i";
         8'hB4, 8'hB6, 8'h94, 8'h96:                             return "o";
         8'hB9, 8'hBB, 8'hBC, 8'h99, 8'h9B, 8'h9C:               return "u";
         8'hA7, 8'h87:                                           return "c";
         default:                                                return 8'h00;
      endcase
   endfunction

   function automatic logic is_lead2(input logic [7:0] b);
      return (b & LEAD2_MASK) == LEAD2_CODE;
   endfunction

   function automatic ufks_emit_type fold_two(input logic [7:0] b0, input logic [7:0] b1);
      ufks_emit_type e;
      logic [7:0]    f;
      e = '0;
      f = fold_latin(b1);
      if (b0 == LEAD_LATIN) begin
         if (f != 8'h00) begin
            e.count  = 2'd1;
            e.char_a = f;
         end
      end else if (b0 == LEAD_OE && b1 == CONT_OE) begin
         e.count  = 2'd2;
         e.pair   = 1'b1;
         e.char_a = "o";
         e.char_b = "e";
      end
      return e;
   endfunction

   function automatic ufks_emit_type refold(input logic [7:0] x, input logic [7:0] y);
      ufks_emit_type e;
      e = '0;
      if (!x[7]) begin
         e.count  = 2'd1;
         e.char_a = to_lower(x);
         if (!y[7]) begin
            e.count  = 2'd2;
            e.char_b = to_lower(y);
         end
      end else if (is_lead2(x)) begin
         e = fold_two(x, y);
      end else if (!y[7]) begin
         e.count  = 2'd1;
         e.char_a = to_lower(y);
      end
      return e;
   endfunction

   always_comb begin
      held0_in  = held0_ff;
      held1_in  = held1_ff;
      held2_in  = held2_ff;
      hcount_in = hcount_ff;
      need_in   = need_ff;
      emit      = '0;
      if (hcount_ff == 2'd0) begin
         if (is_lead2(text_byte)) begin
            held0_in  = text_byte;
            hcount_in = 2'd1;
            need_in   = 2'd1;
         end else if ((text_byte & LEAD3_MASK) == LEAD3_CODE) begin
            held0_in  = text_byte;
            hcount_in = 2'd1;
            need_in   = 2'd2;
         end else if ((text_byte & LEAD4_MASK) == LEAD4_CODE) begin
            held0_in  = text_byte;
            hcount_in = 2'd1;
            need_in   = 2'd3;
         end else if (!text_byte[7]) begin
            emit.count  = 2'd1;
            emit.char_a = to_lower(text_byte);
         end
      end else if (need_ff <= 2'd1 || hcount_ff == 2'd3) begin
         if (hcount_ff == 2'd1 && is_lead2(held0_ff)) begin
            emit = fold_two(held0_ff, text_byte);
         end
         hcount_in = 2'd0;
         need_in   = 2'd0;
      end else begin
         if (hcount_ff == 2'd1) begin
            held1_in = text_byte;
         end else begin
            held2_in = text_byte;
         end
         hcount_in = hcount_ff + 2'd1;
         need_in   = need_ff - 2'd1;
      end
      if (last_byte) begin
         if (hcount_in == 2'd2) begin
            if (!held1_in[7]) begin
               emit.count  = 2'd1;
               emit.char_a = to_lower(held1_in);
            end
         end else if (hcount_in == 2'd3) begin
            emit = refold(held1_in, held2_in);
         end
         hcount_in = 2'd0;
         need_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hcount_ff <= 2'd0;
         need_ff   <= 2'd0;
      end else if (accept) begin
         hcount_ff <= hcount_in;
         need_ff   <= need_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held0_ff <= held0_in;
         held1_ff <= held1_in;
         held2_ff <= held2_in;
      end
   end

endmodule
`default_nettype wire

@@ src/ufks_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ufks_cell: one character cell of the history chain
// Takes the character of the next or second-next cell as the chain advances.
// ----------------------------------------------------------------------------
module ufks_cell import ufks_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          clear,
   input  wire ufks_shift_type shift,
   input  wire logic [7:0]    near_char,
   input  wire logic [7:0]    far_char,
   output      logic [7:0]    char_out
);

   logic [7:0] char_ff, char_in;

   always_comb begin
      case (shift)
         SHIFT_ONE: char_in = near_char;
         SHIFT_TWO: char_in = far_char;
         default:   char_in = char_ff;
      endcase
      if (clear) begin
         char_in = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_ff <= 8'h00;
      end else begin
         char_ff <= char_in;
      end
   end

   assign char_out = char_ff;

endmodule
`default_nettype wire

@@ src/ufks_rsp_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ufks_rsp_queue: two-entry result queue
// Output register plus skid entry between the match logic and the consumer.
// ----------------------------------------------------------------------------
module ufks_rsp_queue import ufks_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire ufks_rsp_type  push_item,
   output      logic          full,
   output      logic          rsp_valid,
   input  wire logic          rsp_stall,
   output      ufks_rsp_type  rsp_item
);

   logic         head_valid_ff, head_valid_in;
   logic         tail_valid_ff, tail_valid_in;
   ufks_rsp_type head_ff, head_in;
   ufks_rsp_type tail_ff, tail_in;
   logic         pop;

   assign pop = head_valid_ff & ~rsp_stall;

   always_comb begin
      head_valid_in = pop ? tail_valid_ff : head_valid_ff;
      head_in       = pop ? tail_ff : head_ff;
      tail_valid_in = pop ? 1'b0 : tail_valid_ff;
      tail_in       = tail_ff;
      if (push) begin
         if (!head_valid_in) begin
            head_valid_in = 1'b1;
            head_in       = push_item;
         end else begin
            tail_valid_in = 1'b1;
            tail_in       = push_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign full      = head_valid_ff & tail_valid_ff;
   assign rsp_valid = head_valid_ff;
   assign rsp_item  = head_ff;

endmodule
`default_nettype wire

@@ src/utf8_fold_keyword_spotter_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_fold_keyword_spotter_unit: UTF-8 fold and keyword spotter
// One byte per cycle while req_stall is low; the last byte's result is queued.
// Throughput is one byte per cycle while the two-entry result queue drains;
// req_stall rises only when both queue entries wait.
// Synchronous reset clears the history cells, hit flags, count, held
// sequence, enable register and result queue.
// ----------------------------------------------------------------------------
module utf8_fold_keyword_spotter_unit import ufks_pkg::*; #(
   parameter int FOLD_CAPACITY  = 256,
   parameter int KEYWORD_COUNT  = 8,
   parameter int HISTORY_LENGTH = 12
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_stall,
   input  wire ufks_req_type  req_item,
   output      logic          rsp_valid,
   input  wire logic          rsp_stall,
   output      ufks_rsp_type  rsp_item,
   input  wire logic          csr_write_enable,
   input  wire logic          csr_write_data
);

   localparam int CNT_W = $clog2(FOLD_CAPACITY);
   localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(FOLD_CAPACITY - 1);
   localparam logic [KW_TABLE-1:0] KW_MASK = KW_TABLE'((1 << KEYWORD_COUNT) - 1);

   logic                accept, finish, queue_full;
   logic                enabled_ff;
   ufks_emit_type       emit;
   logic [CNT_W-1:0]    count_ff, count_in, count_sum, room;
   logic [KW_TABLE-1:0] hits_ff, hits_in, hits_a, hits_b;
   logic [1:0]          n_push;
   ufks_shift_type      shift;
   logic [7:0]          hist [HISTORY_LENGTH];
   ufks_window_type     win_a, win_b;
   logic [LEN_W-1:0]    folded_len;
   logic [2:0]          kw_index;
   ufks_rsp_type        result;

   assign accept    = req_valid & ~req_stall;
   assign finish    = accept & req_item.last_byte;
   assign req_stall = queue_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
      end else if (csr_write_enable) begin
         enabled_ff <= csr_write_data;
      end
   end

   ufks_fold u_fold (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .text_byte (req_item.text_byte),
      .last_byte (req_item.last_byte),
      .emit      (emit)
   );

   assign room = COUNT_MAX - count_ff;

   always_comb begin
      n_push = 2'd0;
      if (emit.pair) begin
         n_push = (room >= CNT_W'(2)) ? 2'd2 : 2'd0;
      end else if (emit.count == 2'd1) begin
         n_push = (room >= CNT_W'(1)) ? 2'd1 : 2'd0;
      end else if (emit.count == 2'd2) begin
         if (room >= CNT_W'(2)) begin
            n_push = 2'd2;
         end else if (room >= CNT_W'(1)) begin
            n_push = 2'd1;
         end
      end
      if (!accept) begin
         n_push = 2'd0;
      end
      case (n_push)
         2'd1:    shift = SHIFT_ONE;
         2'd2:    shift = SHIFT_TWO;
         default: shift = SHIFT_HOLD;
      endcase
   end

   for (genvar i = 0; i < HISTORY_LENGTH; i++) begin : g_cell
      logic [7:0] near_char, far_char;
      if (i == HISTORY_LENGTH - 1) begin : g_last
         assign near_char = emit.char_a;
         assign far_char  = emit.char_b;
      end else if (i == HISTORY_LENGTH - 2) begin : g_next
         assign near_char = hist[i+1];
         assign far_char  = emit.char_a;
      end else begin : g_body
         assign near_char = hist[i+1];
         assign far_char  = hist[i+2];
      end
      ufks_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .clear     (finish),
         .shift     (shift),
         .near_char (near_char),
         .far_char  (far_char),
         .char_out  (hist[i])
      );
   end

   always_comb begin
      for (int j = 0; j < KW_WINDOW; j++) begin
         win_a[j] = hist[HISTORY_LENGTH - KW_WINDOW + j];
      end
      for (int j = 0; j < KW_WINDOW - 1; j++) begin
         win_b[j] = win_a[j+1];
      end
      win_b[KW_WINDOW-1] = emit.char_a;
   end

   assign hits_a = kw_match(win_a, emit.char_a);
   assign hits_b = kw_match(win_b, emit.char_b);

   always_comb begin
      hits_in = hits_ff;
      if (n_push != 2'd0) begin
         hits_in = hits_in | (hits_a & KW_MASK);
      end
      if (n_push == 2'd2) begin
         hits_in = hits_in | (hits_b & KW_MASK);
      end
      kw_index = 3'd0;
      for (int k = KW_TABLE - 1; k >= 0; k--) begin
         if (hits_in[k]) begin
            kw_index = 3'(k);
         end
      end
   end

   assign count_sum = count_ff + CNT_W'(n_push);
   assign count_in  = finish ? '0 : count_sum;

   if (CNT_W > LEN_W) begin : g_sat
      assign folded_len = (count_sum > CNT_W'(2**LEN_W - 1)) ? '1 : count_sum[LEN_W-1:0];
   end else begin : g_nosat
      assign folded_len = LEN_W'(count_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         hits_ff  <= '0;
      end else if (accept) begin
         count_ff <= count_in;
         hits_ff  <= finish ? '0 : hits_in;
      end
   end

   always_comb begin
      result.any_keyword   = |hits_in;
      result.hint_request  = enabled_ff & req_item.is_final & (|hits_in);
      result.keyword_index = kw_index;
      result.folded_length = folded_len;
   end

   ufks_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (finish),
      .push_item (result),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire

@@ src/ufks_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ufks_checker: port-level checks of the keyword spotter
// Watches the result channel and input stall over time; bound to the top level.
// ----------------------------------------------------------------------------
module ufks_checker import ufks_pkg::*; (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_stall,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire ufks_rsp_type rsp_item
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result transaction changed while stalled");

   a_hint_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_item.hint_request || rsp_item.any_keyword)
      else $error("hint request without a keyword hit");

   a_index_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.any_keyword |-> rsp_item.keyword_index == 3'd0)
      else $error("keyword index set without a hit");

   a_stall_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with no result waiting");

endmodule

bind utf8_fold_keyword_spotter_unit ufks_checker u_ufks_checker (.*);
`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: UTF-8 fold and keyword spotter
// Streams transcript bytes through the spotter under random sender gaps and
// receiver stalls. A predictor folds the same bytes, tracks the keyword hits
// and queues one expected report per string; every report that the block
// hands over is checked field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module testbench;
   import ufks_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 120;
   localparam int HIST_DEPTH  = 12;
   localparam int FOLD_ROOM   = 255;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_EVERY_THIRD} stall_mode_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   ufks_req_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   ufks_rsp_type rsp_item;
   logic         csr_write_enable = 1'b0;
   logic         csr_write_data = 1'b0;

   string kw_words [KW_TABLE] = '{
      "indice", "aide", "hint", "bloque", "perdu",
      "comment faire", "je sais pas", "sais pas"
   };

   // predictor state
   logic [7:0]      char_hist [HIST_DEPTH];
   logic [7:0]      kw_hits;
   int              fold_count;
   logic [2:0][7:0] held;
   int              held_n;
   int              need_n;
   logic            enable_reg;

   ufks_rsp_type expected_reports [$];
   ufks_rsp_type want_report;
   logic [7:0]   text_q [$];
   bit           failed = 1'b0;
   int           burst_left = 0;
   int           quiet_cycles = 0;
   int           hold_requests = 0;
   int           hold_served = 0;
   int           hold_left = 0;
   int           mode_left = 0;
   int           phase_count = 0;
   stall_mode_type stall_mode = STALL_NONE;

   utf8_fold_keyword_spotter_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------ predictor

   task automatic clear_spotter();
      for (int i = 0; i < HIST_DEPTH; i++) char_hist[i] = 8'h00;
      kw_hits = '0;
      fold_count = 0;
      held = '0;
      held_n = 0;
      need_n = 0;
   endtask

   task automatic push_folded_char(input logic [7:0] c);
      int  n;
      bit  hit;
      for (int k = 0; k < KW_TABLE; k++) begin
         n = kw_words[k].len();
         hit = (kw_words[k][n-1] == c);
         for (int i = 0; hit && i + 1 < n; i++) begin
            if (kw_words[k][n-2-i] != char_hist[HIST_DEPTH-1-i]) hit = 1'b0;
         end
         if (hit) kw_hits[k] = 1'b1;
      end
      for (int i = 0; i + 1 < HIST_DEPTH; i++) char_hist[i] = char_hist[i+1];
      char_hist[HIST_DEPTH-1] = c;
      fold_count++;
   endtask

   function automatic logic [7:0] latin_base(input logic [7:0] b1);
      case (b1)
         8'hA9, 8'hA8, 8'hAA, 8'hAB, 8'h89, 8'h88, 8'h8A, 8'h8B: return "e";
         8'hA0, 8'hA2, 8'hA4, 8'h80, 8'h82, 8'h84: return "a";
         8'hAE, 8'hAF, 8'h8E, 8'h8F: return "i";
         8'hB4, 8'hB6, 8'h94, 8'h96: return "o";
         8'hB9, 8'hBB, 8'hBC, 8'h99, 8'h9B, 8'h9C: return "u";
         8'hA7, 8'h87: return "c";
         default: return 8'h00;
      endcase
   endfunction

   task automatic fold_run(input logic [3:0][7:0] seq, input int n);
      int         pos;
      int         rest;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] f;
      pos = 0;
      while (pos < n) begin
         b0 = seq[pos];
         rest = n - pos;
         if (fold_count >= FOLD_ROOM) return;
         if (b0 < 8'h80) begin
            f = b0;
            if (f >= "A" && f <= "Z") f = f + 8'd32;
            push_folded_char(f);
            pos += 1;
         end else if ((b0 & LEAD2_MASK) == LEAD2_CODE && rest >= 2) begin
            b1 = seq[pos+1];
            if (b0 == LEAD_LATIN) begin
               f = latin_base(b1);
               if (f != 8'h00) push_folded_char(f);
            end else if (b0 == LEAD_OE && b1 == CONT_OE) begin
               if (FOLD_ROOM - fold_count >= 2) begin
                  push_folded_char("o");
                  push_folded_char("e");
               end
            end
            pos += 2;
         end else if ((b0 & LEAD3_MASK) == LEAD3_CODE && rest >= 3) begin
            pos += 3;
         end else if ((b0 & LEAD4_MASK) == LEAD4_CODE && rest >= 4) begin
            pos += 4;
         end else begin
            pos += 1;
         end
      end
   endtask

   task automatic advance_spotter(input ufks_req_type r);
      logic [3:0][7:0] seq;
      logic [7:0]      b;
      int              total;
      int              n;
      ufks_rsp_type    rep;
      b = r.text_byte;
      seq = '0;
      if (held_n == 0) begin
         total = 1;
         if ((b & LEAD2_MASK) == LEAD2_CODE) total = 2;
         else if ((b & LEAD3_MASK) == LEAD3_CODE) total = 3;
         else if ((b & LEAD4_MASK) == LEAD4_CODE) total = 4;
         if (total == 1) begin
            seq[0] = b;
            fold_run(seq, 1);
         end else begin
            held[0] = b;
            held_n = 1;
            need_n = total - 1;
         end
      end else begin
         n = held_n;
         for (int k = 0; k < n; k++) seq[k] = held[k];
         seq[n] = b;
         if (need_n <= 1 || n >= 3) begin
            fold_run(seq, n + 1);
            held_n = 0;
            need_n = 0;
         end else begin
            held[n] = b;
            held_n = n + 1;
            need_n = need_n - 1;
         end
      end
      if (!r.last_byte) return;
      // refold what follows a truncated lead
      if (held_n > 0) begin
         seq = '0;
         for (int k = 1; k < held_n; k++) seq[k-1] = held[k];
         fold_run(seq, held_n - 1);
      end
      rep = '0;
      for (int k = KW_TABLE - 1; k >= 0; k--) begin
         if (kw_hits[k]) rep.keyword_index = 3'(k);
      end
      rep.any_keyword = |kw_hits;
      rep.hint_request = enable_reg & r.is_final & (|kw_hits);
      rep.folded_length = (fold_count > 255) ? 8'd255 : 8'(fold_count);
      expected_reports.push_back(rep);
      clear_spotter();
   endtask

   // ------------------------------------------------------------------ checking

   task automatic report_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failed = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         enable_reg = 1'b0;
         clear_spotter();
      end else begin
         if (csr_write_enable) enable_reg = csr_write_data;
         if (req_valid && !req_stall) advance_spotter(req_item);
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected report, expected none, actual %p", $time, rsp_item);
               failed = 1'b1;
            end else begin
               want_report = expected_reports.pop_front();
               report_field("hint_request", want_report.hint_request, rsp_item.hint_request);
               report_field("any_keyword", want_report.any_keyword, rsp_item.any_keyword);
               report_field("keyword_index", want_report.keyword_index,
                            rsp_item.keyword_index);
               report_field("folded_length", want_report.folded_length,
                            rsp_item.folded_length);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------ receiver

   always @(negedge clock) begin
      phase_count++;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
               STALL_NONE: rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= (phase_count % 3 == 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------ sender

   task automatic send_byte(input logic [7:0] b, input logic last, input logic fin);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_item <= '{text_byte: b, last_byte: last, is_final: fin};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text(input logic fin);
      int last_pos;
      last_pos = text_q.size() - 1;
      for (int i = 0; i <= last_pos; i++) begin
         send_byte(text_q[i], i == last_pos, (i == last_pos) ? fin : 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic load_text(input string s);
      text_q.delete();
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   task automatic drain_reports();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_enable(input logic value);
      drain_reports();
      csr_write_data <= value;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic add_keyword_token();
      string      w;
      int         cut;
      logic [7:0] ch;
      w = kw_words[$urandom_range(0, KW_TABLE - 1)];
      cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w.len()) : w.len();
      for (int j = 0; j < cut; j++) begin
         ch = w[j];
         if (ch == "e" && $urandom_range(0, 4) == 0) begin
            text_q.push_back(LEAD_LATIN);
            text_q.push_back(8'(($urandom_range(0, 1) ? 8'hA8 : 8'h88) + $urandom_range(0, 3)));
         end else if (ch >= "a" && ch <= "z" && $urandom_range(0, 3) == 0) begin
            text_q.push_back(ch - 8'd32);
         end else begin
            text_q.push_back(ch);
         end
      end
   endtask

   task automatic build_random_text(input int max_tokens);
      int pick;
      text_q.delete();
      repeat ($urandom_range(1, max_tokens)) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            add_keyword_token();
         end else if (pick < 50) begin
            repeat ($urandom_range(1, 5)) text_q.push_back(8'($urandom_range("a", "z")));
         end else if (pick < 60) begin
            text_q.push_back(LEAD_LATIN);
            text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
         end else if (pick < 65) begin
            text_q.push_back(LEAD_OE);
            text_q.push_back($urandom_range(0, 1) ? CONT_OE : 8'($urandom_range(8'h80, 8'hBF)));
         end else if (pick < 70) begin
            text_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            repeat (2) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
         end else if (pick < 75) begin
            text_q.push_back(8'($urandom_range(8'hF0, 8'hF7)));
            repeat (3) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
         end else if (pick < 85) begin
            text_q.push_back(8'($urandom_range(0, 255)));
         end else begin
            text_q.push_back(" ");
         end
      end
   endtask

   // ------------------------------------------------------------------ tests

   task automatic test_directed_text();
      // keyword with the block still disabled
      load_text("aide");
      send_text(1'b1);
      write_enable(1'b1);
      load_text("Hint");
      send_text(1'b1);
      text_q = '{8'h00, 8'h01, 8'h7F, 8'hFF};
      send_text(1'b1);
      load_text("aid");
      text_q.push_back(LEAD_LATIN);
      text_q.push_back(8'hA9);
      send_text(1'b1);
      text_q = '{LEAD_OE, CONT_OE, 8'hE2, 8'h41};
      send_text(1'b1);
      text_q = '{8'hF0, LEAD_LATIN, 8'hA9};
      send_text(1'b0);
      text_q = '{8'h80, LEAD_LATIN};
      send_text(1'b1);
      text_q = '{8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h7A};
      send_text(1'b1);
   endtask

   task automatic test_fold_capacity();
      // oe that no longer fits, then a single character that does
      text_q.delete();
      repeat (254) text_q.push_back(8'($urandom_range("x", "z")));
      text_q.push_back(LEAD_OE);
      text_q.push_back(CONT_OE);
      text_q.push_back("b");
      send_text(1'b1);
      // keyword straddling the end of the kept text
      text_q.delete();
      repeat (248) text_q.push_back(8'($urandom_range("a", "z")));
      load_text({"abc", "je sais pas"});
      for (int i = 0; i < 248; i++) text_q.push_front(8'($urandom_range("x", "z")));
      repeat (40) text_q.push_back(8'($urandom_range(0, 255)));
      send_text(1'b1);
   endtask

   task automatic test_result_backlog();
      drain_reports();
      @(posedge clock);
      hold_requests++;
      @(negedge clock);
      repeat (40) begin
         build_random_text(2);
         send_text(1'($urandom_range(0, 1)));
      end
   endtask

   task automatic test_random_text(input int byte_budget);
      int sent;
      sent = 0;
      while (sent < byte_budget) begin
         build_random_text(10);
         sent += text_q.size();
         send_text(1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      test_directed_text();
      test_fold_capacity();
      test_result_backlog();
      write_enable(1'b0);
      test_random_text(250);
      write_enable(1'b1);
      test_random_text(300);
      write_enable(1'b0);
      test_random_text(150);
      write_enable(1'b1);
      test_random_text(300);
      drain_reports();
      repeat (8) @(posedge clock);
      if (failed || expected_reports.size() != 0) begin
         $display("Test completed with failures");
      end else begin
         $display("Test completed successfully");
      end
      $finish;
   end

endmodule
